/* sv/trle_pkg.sv */
package trle_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_ROWS    = 4096;

    localparam int PIX_W       = 8;
    localparam int THR_W       = 9;
    localparam int WIDTH_W     = 13;
    localparam int COL_W       = 12;
    localparam int ROW_W       = 12;
    localparam int CNT_W       = 13;
    localparam int CLS_W       = 2;
    localparam int REG_IDX_W   = 2;
    localparam int REG_DATA_W  = 13;

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [REG_IDX_W-1:0] REG_BLACK_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRAY_THRESHOLD  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH       = 2'd2;

    localparam logic [THR_W-1:0]   BLACK_THRESHOLD_RST = 9'd85;
    localparam logic [THR_W-1:0]   GRAY_THRESHOLD_RST  = 9'd170;
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST       = 13'd640;

    localparam logic [CNT_W-1:0] START_ADJUST = 13'd2;

    typedef enum logic [CLS_W-1:0] {
        CLS_BLACK = 2'd0,
        CLS_GRAY  = 2'd1,
        CLS_WHITE = 2'd2
    } class_t;

    typedef struct packed {
        logic [CNT_W-1:0] start_x;
        logic [CNT_W-1:0] run_length;
        class_t           color;
    } run_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             has_a;
        run_t             a;
        logic             has_b;
        run_t             b;
    } entry_t;

endpackage

/* sv/trle_front.sv */
module trle_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic [trle_pkg::PIX_W-1:0]          pixel,
    input  logic                                frame_start,
    input  logic                                wr_en,
    input  logic [trle_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [trle_pkg::REG_DATA_W-1:0]     wr_data,
    output logic                                entry_wr,
    output trle_pkg::entry_t                    entry
);

    logic [trle_pkg::THR_W-1:0]   black_thr_reg;
    logic [trle_pkg::THR_W-1:0]   gray_thr_reg;
    logic [trle_pkg::WIDTH_W-1:0] row_width_reg;

    logic [trle_pkg::COL_W-1:0] col_reg, col_next;
    logic [trle_pkg::ROW_W-1:0] row_reg, row_next;
    logic [trle_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    trle_pkg::class_t           cls_reg, cls_next;

    logic                         accept;
    logic [trle_pkg::WIDTH_W-1:0] w;
    logic [trle_pkg::COL_W-1:0]   c;
    logic [trle_pkg::ROW_W-1:0]   r;
    logic [trle_pkg::CNT_W-1:0]   rc;
    logic [trle_pkg::CNT_W-1:0]   rc_new;
    logic [trle_pkg::CNT_W-1:0]   c_ext;
    trle_pkg::class_t             cur;
    trle_pkg::class_t             cls;
    logic                         last_col;
    logic                         same;
    logic [trle_pkg::CNT_W-1:0]   start_a;
    logic [trle_pkg::CNT_W-1:0]   start_b;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_thr_reg <= trle_pkg::BLACK_THRESHOLD_RST;
            gray_thr_reg  <= trle_pkg::GRAY_THRESHOLD_RST;
            row_width_reg <= trle_pkg::ROW_WIDTH_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                trle_pkg::REG_BLACK_THRESHOLD: black_thr_reg <= wr_data[trle_pkg::THR_W-1:0];
                trle_pkg::REG_GRAY_THRESHOLD:  gray_thr_reg  <= wr_data[trle_pkg::THR_W-1:0];
                trle_pkg::REG_ROW_WIDTH:       row_width_reg <= wr_data[trle_pkg::WIDTH_W-1:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        if (row_width_reg == '0)
            w = trle_pkg::WIDTH_W'(1);
        else if (row_width_reg > trle_pkg::WIDTH_W'(trle_pkg::MAX_WIDTH))
            w = trle_pkg::WIDTH_W'(trle_pkg::MAX_WIDTH);
        else
            w = row_width_reg;

        c   = frame_start ? '0 : col_reg;
        r   = frame_start ? '0 : row_reg;
        rc  = frame_start ? '0 : cnt_reg;
        cur = frame_start ? trle_pkg::CLS_BLACK : cls_reg;

        if ({1'b0, pixel} < black_thr_reg)
            cls = trle_pkg::CLS_BLACK;
        else if ({1'b0, pixel} < gray_thr_reg)
            cls = trle_pkg::CLS_GRAY;
        else
            cls = trle_pkg::CLS_WHITE;

        c_ext    = trle_pkg::CNT_W'(c);
        last_col = trle_pkg::WIDTH_W'(c) >= (w - trle_pkg::WIDTH_W'(1));
        same     = (cls == cur);
        rc_new   = same ? rc + trle_pkg::CNT_W'(1) : trle_pkg::CNT_W'(1);

        start_a = c_ext - rc + trle_pkg::CNT_W'(1);
        if ((c_ext == rc) || last_col)
            start_a = start_a + trle_pkg::START_ADJUST;

        start_b = trle_pkg::CNT_W'(w) - rc_new;
        if (rc_new >= trle_pkg::CNT_W'(w))
            start_b = start_b + trle_pkg::START_ADJUST;

        entry.row          = r;
        entry.has_a        = !same && (rc != '0);
        entry.a.start_x    = start_a;
        entry.a.run_length = rc;
        entry.a.color      = cur;
        entry.has_b        = last_col;
        entry.b.start_x    = start_b;
        entry.b.run_length = rc_new;
        entry.b.color      = cls;

        entry_wr = accept && (entry.has_a || entry.has_b);

        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        cls_next = cls_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                cnt_next = '0;
                cls_next = trle_pkg::CLS_BLACK;
                if (r == trle_pkg::ROW_W'(trle_pkg::MAX_ROWS - 1))
                    row_next = '0;
                else
                    row_next = r + trle_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = c + trle_pkg::COL_W'(1);
                row_next = r;
                cnt_next = rc_new;
                cls_next = cls;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
            cls_reg <= trle_pkg::CLS_BLACK;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            cls_reg <= cls_next;
        end
    end

endmodule

/* sv/trle_queue.sv */
module trle_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  trle_pkg::entry_t wr_data,
    output logic             full,
    input  logic             rd,
    output trle_pkg::entry_t rd_data,
    output logic             empty
);

    trle_pkg::entry_t             slot_reg [trle_pkg::QDEPTH];
    logic [trle_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [trle_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [trle_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                         do_wr;
    logic                         do_rd;

    assign full    = (count_reg == trle_pkg::QCNT_W'(trle_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            if (wr_ptr_reg == trle_pkg::QPTR_W'(trle_pkg::QDEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + trle_pkg::QPTR_W'(1);
        end
        if (do_rd)
        begin
            if (rd_ptr_reg == trle_pkg::QPTR_W'(trle_pkg::QDEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + trle_pkg::QPTR_W'(1);
        end
        if (do_wr && !do_rd)
            count_next = count_reg + trle_pkg::QCNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - trle_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/trle_back.sv */
module trle_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trle_pkg::entry_t              head,
    input  logic                          head_empty,
    output logic                          head_rd,
    input  logic                          pop,
    output logic                          empty,
    output logic [trle_pkg::ROW_W-1:0]    row,
    output logic [trle_pkg::CNT_W-1:0]    start_x,
    output logic [trle_pkg::CNT_W-1:0]    run_length,
    output logic [trle_pkg::CLS_W-1:0]    color,
    output logic                          last
);

    logic                       valid_reg, valid_next;
    logic                       phase_reg, phase_next;
    logic [trle_pkg::ROW_W-1:0] row_reg;
    trle_pkg::run_t             run_reg;
    logic                       last_reg;

    logic                       out_xfer;
    logic                       load;
    trle_pkg::run_t             sel;
    logic                       sel_last;

    assign out_xfer = pop && valid_reg;
    assign load     = !head_empty && (!valid_reg || out_xfer);

    always_comb
    begin
        phase_next = phase_reg;
        head_rd    = 1'b0;
        if (phase_reg)
        begin
            sel      = head.b;
            sel_last = 1'b1;
        end
        else
        begin
            sel      = head.has_a ? head.a : head.b;
            sel_last = !(head.has_a && head.has_b);
        end
        if (load)
        begin
            if (sel_last)
            begin
                phase_next = 1'b0;
                head_rd    = 1'b1;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end

        if (load)
            valid_next = 1'b1;
        else if (out_xfer)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= head.row;
            run_reg  <= sel;
            last_reg <= sel_last;
        end
    end

    assign empty      = !valid_reg;
    assign row        = row_reg;
    assign start_x    = run_reg.start_x;
    assign run_length = run_reg.run_length;
    assign color      = run_reg.color;
    assign last       = last_reg;

endmodule

/* sv/three_level_row_run_length_encoder.sv */
// Channel   Direction  Handshake                 Payload
// pixel in  input      push / full               pixel, frame_start
// runs out  output     pop / empty               row, start_x, run_length, color, last
// config    input      wr_en, wr_index           wr_data
//
// A pixel is taken every cycle while full is low; the front updates the row state
// in that cycle and queues up to two runs in a four-entry queue.
// The back drains one run per cycle into the output register while that register is
// empty or being popped, so a pixel closing two runs leaves as two separate runs; full rises only when the queue fills.
// Reset restores the threshold and width registers and clears all row state.
module three_level_row_run_length_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [trle_pkg::PIX_W-1:0]          pixel,
    input  logic                                frame_start,
    output logic                                empty,
    input  logic                                pop,
    output logic [trle_pkg::ROW_W-1:0]          row,
    output logic [trle_pkg::CNT_W-1:0]          start_x,
    output logic [trle_pkg::CNT_W-1:0]          run_length,
    output logic [trle_pkg::CLS_W-1:0]          color,
    output logic                                last,
    input  logic                                wr_en,
    input  logic [trle_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [trle_pkg::REG_DATA_W-1:0]     wr_data
);

    logic             entry_wr;
    trle_pkg::entry_t entry;
    trle_pkg::entry_t head;
    logic             head_empty;
    logic             head_rd;

    trle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .frame_start (frame_start),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .entry_wr    (entry_wr),
        .entry       (entry)
    );

    trle_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (entry_wr),
        .wr_data (entry),
        .full    (full),
        .rd      (head_rd),
        .rd_data (head),
        .empty   (head_empty)
    );

    trle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_rd    (head_rd),
        .pop        (pop),
        .empty      (empty),
        .row        (row),
        .start_x    (start_x),
        .run_length (run_length),
        .color      (color),
        .last       (last)
    );

endmodule

/* tb/three_level_row_run_length_encoder_tb.sv */
`timescale 1ns / 1ps
module three_level_row_run_length_encoder_tb;

    localparam logic [trle_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 16;
    localparam int RANDOM_CHUNKS = 12;
    localparam int CHUNK_PIXELS  = 105;

    typedef struct packed {
        logic [trle_pkg::PIX_W-1:0] value;
        logic                       frame_first;
    } pix_t;

    typedef struct packed {
        logic [trle_pkg::ROW_W-1:0] row;
        logic [trle_pkg::CNT_W-1:0] start_x;
        logic [trle_pkg::CNT_W-1:0] run_length;
        trle_pkg::class_t           color;
        logic                       last;
    } run_rec_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic [trle_pkg::PIX_W-1:0]      pixel = '0;
    logic                            frame_start = 1'b0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [trle_pkg::ROW_W-1:0]      row;
    logic [trle_pkg::CNT_W-1:0]      start_x;
    logic [trle_pkg::CNT_W-1:0]      run_length;
    logic [trle_pkg::CLS_W-1:0]      color;
    logic                            last;
    logic                            wr_en = 1'b0;
    logic [trle_pkg::REG_IDX_W-1:0]  wr_index = '0;
    logic [trle_pkg::REG_DATA_W-1:0] wr_data = '0;

    // predictor copy of the registers and the row state
    logic [trle_pkg::THR_W-1:0]   black_thr = trle_pkg::BLACK_THRESHOLD_RST;
    logic [trle_pkg::THR_W-1:0]   gray_thr = trle_pkg::GRAY_THRESHOLD_RST;
    logic [trle_pkg::WIDTH_W-1:0] width_cfg = trle_pkg::ROW_WIDTH_RST;
    int                           col_idx = 0;
    int                           row_idx = 0;
    int                           run_len = 0;
    trle_pkg::class_t             run_cls = trle_pkg::CLS_BLACK;

    pix_t     pixel_backlog[$];
    run_rec_t runs_due[$];
    pix_t     next_pix;
    run_rec_t due_run;

    int send_idle = 19;
    int recv_idle = 81;
    logic hold_send = 1'b0;
    int pixels_taken = 0;
    int runs_checked = 0;
    int reg_writes = 0;
    int error_count = 0;
    int stall_cycles = 0;

    three_level_row_run_length_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .frame_start(frame_start),
        .empty      (empty),
        .pop        (pop),
        .row        (row),
        .start_x    (start_x),
        .run_length (run_length),
        .color      (color),
        .last       (last),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic emit_run(input int s, input int len, input trle_pkg::class_t k,
                            input logic fin);
        run_rec_t r;
        r.row        = row_idx[trle_pkg::ROW_W-1:0];
        r.start_x    = s[trle_pkg::CNT_W-1:0];
        r.run_length = len[trle_pkg::CNT_W-1:0];
        r.color      = k;
        r.last       = fin;
        runs_due     = {runs_due, r};
    endtask

    task automatic encode_pixel(input logic [trle_pkg::PIX_W-1:0] p, input logic fs);
        int w;
        int c;
        int s;
        trle_pkg::class_t k;
        logic end_of_row;
        w = int'(width_cfg);
        if (w < 1)
            w = 1;
        if (w > trle_pkg::MAX_WIDTH)
            w = trle_pkg::MAX_WIDTH;
        if (fs)
        begin
            col_idx = 0;
            row_idx = 0;
            run_len = 0;
            run_cls = trle_pkg::CLS_BLACK;
        end
        if ({1'b0, p} < black_thr)
            k = trle_pkg::CLS_BLACK;
        else if ({1'b0, p} < gray_thr)
            k = trle_pkg::CLS_GRAY;
        else
            k = trle_pkg::CLS_WHITE;
        c = col_idx;
        end_of_row = (c >= w - 1);
        if (k == run_cls)
            run_len = run_len + 1;
        else
        begin
            if (run_len > 0)
            begin
                s = c - run_len + 1;
                if (c == run_len || end_of_row)
                    s = s + 2;
                emit_run(s, run_len, run_cls, !end_of_row);
            end
            run_cls = k;
            run_len = 1;
        end
        if (end_of_row)
        begin
            s = w - run_len;
            if (run_len >= w)
                s = s + 2;
            emit_run(s, run_len, run_cls, 1'b1);
            col_idx = 0;
            run_len = 0;
            run_cls = trle_pkg::CLS_BLACK;
            row_idx = (row_idx + 1) % trle_pkg::MAX_ROWS;
        end
        else
            col_idx = c + 1;
    endtask

    // pixel transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            pixel <= '0;
            frame_start <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                encode_pixel(pixel, frame_start);
                pixels_taken++;
            end
            if (!push || !full)
            begin
                if (pixel_backlog.size() != 0 && !hold_send && $urandom_range(99) >= send_idle)
                begin
                    next_pix = pixel_backlog.pop_front();
                    push <= 1'b1;
                    pixel <= next_pix.value;
                    frame_start <= next_pix.frame_first;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // run transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                runs_checked++;
                if (runs_due.size() == 0)
                begin
                    $error("unexpected run: row %0d start_x %0d run_length %0d color %0d",
                           row, start_x, run_length, color);
                    error_count++;
                end
                else
                begin
                    due_run = runs_due.pop_front();
                    if (row !== due_run.row)
                    begin
                        $error("row: expected %0d, got %0d", due_run.row, row);
                        error_count++;
                    end
                    if (start_x !== due_run.start_x)
                    begin
                        $error("start_x: expected %0d, got %0d", due_run.start_x, start_x);
                        error_count++;
                    end
                    if (run_length !== due_run.run_length)
                    begin
                        $error("run_length: expected %0d, got %0d",
                               due_run.run_length, run_length);
                        error_count++;
                    end
                    if (color !== due_run.color)
                    begin
                        $error("color: expected %0d, got %0d", due_run.color, color);
                        error_count++;
                    end
                    if (last !== due_run.last)
                    begin
                        $error("last: expected %0d, got %0d", due_run.last, last);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, %0d runs outstanding",
                         stall_cycles, runs_due.size());
                $display("three_level_row_run_length_encoder_tb: errors");
                $finish;
            end
            else
                stall_cycles++;
        end
    end

    task automatic write_reg(input logic [trle_pkg::REG_IDX_W-1:0] idx,
                             input logic [trle_pkg::REG_DATA_W-1:0] d);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= d;
        @(posedge clk);
        wr_en <= 1'b0;
        reg_writes++;
        case (idx)
            trle_pkg::REG_BLACK_THRESHOLD: black_thr = d[trle_pkg::THR_W-1:0];
            trle_pkg::REG_GRAY_THRESHOLD:  gray_thr = d[trle_pkg::THR_W-1:0];
            trle_pkg::REG_ROW_WIDTH:       width_cfg = d[trle_pkg::WIDTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_pixel(input logic [trle_pkg::PIX_W-1:0] v, input logic fs);
        pix_t e;
        e.value = v;
        e.frame_first = fs;
        pixel_backlog = {pixel_backlog, e};
    endtask

    // wait until every pixel is in and every run is out, then let the pipe go quiet
    task automatic settle();
        while (pixel_backlog.size() != 0 || push || runs_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    function automatic logic [trle_pkg::THR_W-1:0] thr_value();
        case ($urandom_range(7))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'd511;
            default: return trle_pkg::THR_W'($urandom_range(256));
        endcase
    endfunction

    task automatic scramble_config();
        logic [trle_pkg::REG_DATA_W-1:0] d;
        int pick;
        d = trle_pkg::REG_DATA_W'($urandom_range(8191));
        d[trle_pkg::THR_W-1:0] = thr_value();
        write_reg(trle_pkg::REG_BLACK_THRESHOLD, d);
        d = trle_pkg::REG_DATA_W'($urandom_range(8191));
        d[trle_pkg::THR_W-1:0] = thr_value();
        write_reg(trle_pkg::REG_GRAY_THRESHOLD, d);
        pick = $urandom_range(7);
        if (pick == 0)
            d = '0;
        else if (pick == 1)
            d = trle_pkg::REG_DATA_W'($urandom_range(13, 48));
        else
            d = trle_pkg::REG_DATA_W'($urandom_range(1, 12));
        write_reg(trle_pkg::REG_ROW_WIDTH, d);
    endtask

    task automatic queue_runs(input int n);
        int i;
        int len;
        logic [trle_pkg::PIX_W-1:0] v;
        i = 0;
        while (i < n)
        begin
            case ($urandom_range(7))
                0: v = '0;
                1: v = '1;
                default: v = trle_pkg::PIX_W'($urandom_range(255));
            endcase
            len = $urandom_range(1, 6);
            repeat (len)
            begin
                if ($urandom_range(3) == 0)
                    v = trle_pkg::PIX_W'($urandom_range(255));
                add_pixel(v, $urandom_range(49) == 0);
                i++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // class boundaries, run closes at column 0 and last column, full row run
        write_reg(trle_pkg::REG_ROW_WIDTH, 13'd4);
        add_pixel(8'd0, 1'b1);
        add_pixel(8'd84, 1'b0);
        add_pixel(8'd85, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd170, 1'b0);
        add_pixel(8'd169, 1'b0);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd0, 1'b0);
        repeat (4) add_pixel(8'd255, 1'b0);
        // frame restart drops the open run
        add_pixel(8'd100, 1'b0);
        add_pixel(8'd200, 1'b0);
        add_pixel(8'd50, 1'b1);
        settle();
        // crossed thresholds
        write_reg(trle_pkg::REG_BLACK_THRESHOLD, 13'd200);
        write_reg(trle_pkg::REG_GRAY_THRESHOLD, 13'd100);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd150, 1'b0);
        add_pixel(8'd255, 1'b0);
        settle();
        // zero width acts as one column
        write_reg(trle_pkg::REG_BLACK_THRESHOLD, 13'd0);
        write_reg(trle_pkg::REG_GRAY_THRESHOLD, 13'd256);
        write_reg(trle_pkg::REG_ROW_WIDTH, 13'd0);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd255, 1'b0);
        settle();
        write_reg(trle_pkg::REG_BLACK_THRESHOLD, 13'd85);
        write_reg(trle_pkg::REG_GRAY_THRESHOLD, 13'd170);
        write_reg(REG_UNUSED, 13'd0);
        write_reg(trle_pkg::REG_ROW_WIDTH, 13'd6);
        add_pixel(8'd10, 1'b0);
        add_pixel(8'd90, 1'b0);
        add_pixel(8'd180, 1'b0);
        add_pixel(8'd250, 1'b0);
        settle();
        // shrink the width past the current column
        write_reg(trle_pkg::REG_ROW_WIDTH, 13'd3);
        add_pixel(8'd250, 1'b0);

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            if (chunk == RANDOM_CHUNKS / 3)
            begin
                send_idle = 81;
                recv_idle = 19;
            end
            if (chunk == 2 * RANDOM_CHUNKS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            settle();
            scramble_config();
            queue_runs(CHUNK_PIXELS);
            if (chunk == 2)
            begin
                // hold the sender mid-stream until the output side is drained
                while (pixel_backlog.size() > CHUNK_PIXELS / 2)
                    @(negedge clk);
                hold_send = 1'b1;
                while (push || runs_due.size() != 0)
                    @(negedge clk);
                hold_send = 1'b0;
            end
        end

        // oversized width clamps to the widest row
        settle();
        write_reg(trle_pkg::REG_BLACK_THRESHOLD, 13'd85);
        write_reg(trle_pkg::REG_GRAY_THRESHOLD, 13'd170);
        write_reg(trle_pkg::REG_ROW_WIDTH, 13'h1FFF);
        add_pixel(trle_pkg::PIX_W'($urandom_range(170, 255)), 1'b1);
        queue_runs(20);
        settle();

        $display("%0d pixels in, %0d runs checked, %0d register writes",
                 pixels_taken, runs_checked, reg_writes);
        $display("covered class edges, crossed and extreme thresholds, width clamps, frame restarts");
        if (error_count == 0)
            $display("three_level_row_run_length_encoder_tb: clean");
        else
            $display("three_level_row_run_length_encoder_tb: errors");
        $finish;
    end

endmodule
